FILE: hdl/bsra_pkg.sv
`default_nettype none
package bsra_pkg;

	localparam int MAP_BITS  = 1024;
	localparam int WORD_BITS = 32;
	localparam int NWORDS    = (MAP_BITS + WORD_BITS - 1) / WORD_BITS;

	localparam logic [3:0] OP_FIRST_SET        = 4'd0;
	localparam logic [3:0] OP_LAST_SET         = 4'd1;
	localparam logic [3:0] OP_FIRST_CLEAR      = 4'd2;
	localparam logic [3:0] OP_LAST_CLEAR       = 4'd3;
	localparam logic [3:0] OP_FIRST_SET_FLIP   = 4'd4;
	localparam logic [3:0] OP_LAST_SET_FLIP    = 4'd5;
	localparam logic [3:0] OP_FIRST_CLEAR_FLIP = 4'd6;
	localparam logic [3:0] OP_LAST_CLEAR_FLIP  = 4'd7;
	localparam logic [3:0] OP_ALLOC = 4'd8;
	localparam logic [3:0] OP_FREE  = 4'd9;
	localparam logic [3:0] OP_WRITE = 4'd10;
	localparam logic [3:0] OP_READ  = 4'd11;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_NONE = 2'd1;
	localparam logic [1:0] ST_BAD  = 2'd2;

	typedef struct packed {
		logic        word_we;
		logic [4:0]  word_addr;
		logic [31:0] word_data;
		logic        bit_we;
		logic [9:0]  bit_addr;
		logic        bit_val;
	} wr_cmd_t;

	function automatic logic [4:0] find_low(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

	function automatic logic [4:0] find_high(input logic [31:0] v);
		logic [4:0] r;
		r = '0;
		for (int i = 0; i < 32; i++) begin
			if (v[i]) r = 5'(i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/bsra_map.sv
`default_nettype none
module bsra_map (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [4:0]       rd_addr,
	output logic [31:0]           rd_data,
	input  wire bsra_pkg::wr_cmd_t wr
);

	logic [31:0] words_q [bsra_pkg::NWORDS];

	assign rd_data = words_q[rd_addr];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bsra_pkg::NWORDS; i++) words_q[i] <= '0;
		end else begin
			if (wr.word_we) words_q[wr.word_addr] <= wr.word_data;
			if (wr.bit_we) words_q[wr.bit_addr[9:5]][wr.bit_addr[4:0]] <= wr.bit_val;
		end
	end

endmodule
`default_nettype wire

FILE: hdl/bsra_seq.sv
`default_nettype none
module bsra_seq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [3:0]        opcode,
	input  wire logic [9:0]        start_bit,
	input  wire logic [10:0]       run_length,
	input  wire logic [4:0]        word_index,
	input  wire logic [31:0]       word_value,
	input  wire logic [10:0]       total,
	output logic [4:0]             rd_addr,
	input  wire logic [31:0]       rd_data,
	output bsra_pkg::wr_cmd_t      wr,
	output logic                   done,
	output logic [1:0]             status,
	output logic [9:0]             bit_index,
	output logic [31:0]            word_data
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_ALLOC = 4'b0100,
		S_FILL  = 4'b1000
	} state_t;

	state_t      state_q;
	logic [3:0]  op_q;
	logic [10:0] len_q;
	logic [10:0] ptr_q;
	logic [10:0] run_q;
	logic [10:0] end_q;
	logic        fval_q;
	logic [5:0]  nw_q;
	logic        done_q;
	logic [1:0]  status_q;
	logic [9:0]  idx_q;
	logic [31:0] data_q;

	logic        want, from_top, flip;
	logic [4:0]  scan_w;
	logic [31:0] v;
	logic [4:0]  q;
	logic        cur_bit;
	logic [10:0] run_nx;
	logic [11:0] free_end;
	logic [11:0] nw_sum;
	logic        accept;

	state_t      acc_state;
	logic [1:0]  acc_status;
	logic        acc_done;
	logic [10:0] acc_ptr;
	logic [9:0]  acc_idx;
	logic        acc_read;

	assign busy      = (state_q != S_IDLE);
	assign accept    = start && !busy;
	assign done      = done_q;
	assign status    = status_q;
	assign bit_index = idx_q;
	assign word_data = data_q;

	assign want     = ~op_q[1];
	assign from_top = op_q[0];
	assign flip     = op_q[2];
	assign scan_w   = from_top ? 5'(nw_q - 6'd1 - {1'b0, ptr_q[4:0]}) : ptr_q[4:0];
	assign rd_addr  = (state_q == S_SCAN) ? scan_w : ptr_q[9:5];
	assign v        = want ? rd_data : ~rd_data;
	assign q        = from_top ? bsra_pkg::find_high(v) : bsra_pkg::find_low(v);
	assign cur_bit  = rd_data[ptr_q[4:0]];
	assign run_nx   = cur_bit ? 11'd0 : 11'(run_q + 11'd1);
	assign free_end = {2'b00, start_bit} + {1'b0, run_length};
	assign nw_sum   = {1'b0, total} + 12'd31;

	always_comb begin
		acc_state  = S_IDLE;
		acc_status = bsra_pkg::ST_OK;
		acc_done   = 1'b1;
		acc_ptr    = '0;
		acc_idx    = '0;
		acc_read   = 1'b0;
		if (opcode <= bsra_pkg::OP_LAST_CLEAR_FLIP) begin
			acc_state = S_SCAN;
			acc_done  = 1'b0;
		end else if (opcode == bsra_pkg::OP_ALLOC) begin
			if (run_length == '0 || run_length > total) begin
				acc_status = bsra_pkg::ST_BAD;
			end else begin
				acc_state = S_ALLOC;
				acc_done  = 1'b0;
			end
		end else if (opcode == bsra_pkg::OP_FREE) begin
			if (run_length == '0 || free_end > {1'b0, total}) begin
				acc_status = bsra_pkg::ST_BAD;
			end else begin
				acc_state = S_FILL;
				acc_done  = 1'b0;
				acc_ptr   = {1'b0, start_bit};
				acc_idx   = start_bit;
			end
		end else if (opcode == bsra_pkg::OP_WRITE || opcode == bsra_pkg::OP_READ) begin
			if ({1'b0, word_index} >= 6'(bsra_pkg::NWORDS)) begin
				acc_status = bsra_pkg::ST_BAD;
			end else if (opcode == bsra_pkg::OP_READ) begin
				acc_read = 1'b1;
			end
		end else begin
			acc_status = bsra_pkg::ST_BAD;
		end
	end

	always_comb begin
		wr = '0;
		if (accept && opcode == bsra_pkg::OP_WRITE &&
		    {1'b0, word_index} < 6'(bsra_pkg::NWORDS)) begin
			wr.word_we   = 1'b1;
			wr.word_addr = word_index;
			wr.word_data = word_value;
		end else if (state_q == S_SCAN && v != '0 && flip) begin
			wr.bit_we   = 1'b1;
			wr.bit_addr = {scan_w, q};
			wr.bit_val  = ~want;
		end else if (state_q == S_FILL) begin
			wr.bit_we   = 1'b1;
			wr.bit_addr = ptr_q[9:0];
			wr.bit_val  = fval_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_q     <= '0;
			len_q    <= '0;
			ptr_q    <= '0;
			run_q    <= '0;
			end_q    <= '0;
			fval_q   <= 1'b0;
			nw_q     <= '0;
			done_q   <= 1'b0;
			status_q <= '0;
			idx_q    <= '0;
			data_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					done_q <= accept && acc_done;
					if (accept) begin
						op_q     <= opcode;
						len_q    <= run_length;
						nw_q     <= nw_sum[10:5];
						ptr_q    <= acc_ptr;
						run_q    <= '0;
						idx_q    <= acc_idx;
						data_q   <= acc_read ? rd_data : '0;
						status_q <= acc_status;
						end_q    <= free_end[10:0];
						fval_q   <= 1'b0;
						state_q  <= acc_state;
					end
				end
				S_SCAN: begin
					if (v != '0) begin
						idx_q   <= {scan_w, q};
						done_q  <= 1'b1;
						state_q <= S_IDLE;
					end else if ({1'b0, ptr_q[4:0]} == nw_q - 6'd1) begin
						status_q <= bsra_pkg::ST_NONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						ptr_q  <= ptr_q + 11'd1;
					end
				end
				S_ALLOC: begin
					run_q <= run_nx;
					if (run_nx == len_q) begin
						done_q  <= 1'b0;
						ptr_q   <= 11'(ptr_q + 11'd1 - len_q);
						idx_q   <= 10'(ptr_q + 11'd1 - len_q);
						end_q   <= ptr_q + 11'd1;
						fval_q  <= 1'b1;
						state_q <= S_FILL;
					end else if (ptr_q == total - 11'd1) begin
						status_q <= bsra_pkg::ST_NONE;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						done_q <= 1'b0;
						ptr_q  <= ptr_q + 11'd1;
					end
				end
				S_FILL: begin
					ptr_q  <= ptr_q + 11'd1;
					done_q <= (ptr_q + 11'd1 == end_q);
					if (ptr_q + 11'd1 == end_q) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

FILE: hdl/bitmap_scan_range_allocator_top.sv
`default_nettype none
// Channel   Ports                                                     Handshake
// request   opcode start_bit run_length word_index word_value         start && !busy
// result    status bit_index word_data                                done (one cycle)
// config    map_bits_in_use                                           map_bits_in_use_we
// Write, read and rejected requests raise done in the cycle after acceptance.
// A find scans the words in use (up to 32) from the low or high end until it finds a match,
// one bitmap word through the shared compare and priority encoder per cycle.
// Allocate examines bits until it finds run_length clear bits in a row, then sets that run;
// free clears run_length bits from start_bit, one bit through the single bit write port per cycle.
// Reset clears the whole bitmap at once and sets map_bits_in_use to 1024.
// The result strobe cannot be stalled; busy stays high until the transaction is done.
module bitmap_scan_range_allocator_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [3:0]  opcode,
	input  wire logic [9:0]  start_bit,
	input  wire logic [10:0] run_length,
	input  wire logic [4:0]  word_index,
	input  wire logic [31:0] word_value,
	input  wire logic        map_bits_in_use_we,
	input  wire logic [10:0] map_bits_in_use,
	output logic             done,
	output logic [1:0]       status,
	output logic [9:0]       bit_index,
	output logic [31:0]      word_data
);

	logic [10:0]       map_bits_q;
	logic [10:0]       total;
	logic [4:0]        rd_addr;
	logic [31:0]       rd_data;
	bsra_pkg::wr_cmd_t wr;
	logic [4:0]        map_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_bits_q <= 11'(bsra_pkg::MAP_BITS);
		end else if (map_bits_in_use_we) begin
			map_bits_q <= map_bits_in_use;
		end
	end

	always_comb begin
		priority if (map_bits_q == '0) total = 11'd1;
		else if (map_bits_q > 11'(bsra_pkg::MAP_BITS)) total = 11'(bsra_pkg::MAP_BITS);
		else total = map_bits_q;
	end

	assign map_addr = (!busy) ? word_index : rd_addr;

	bsra_map u_map (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (map_addr),
		.rd_data (rd_data),
		.wr      (wr)
	);

	bsra_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.start_bit  (start_bit),
		.run_length (run_length),
		.word_index (word_index),
		.word_value (word_value),
		.total      (total),
		.rd_addr    (rd_addr),
		.rd_data    (rd_data),
		.wr         (wr),
		.done       (done),
		.status     (status),
		.bit_index  (bit_index),
		.word_data  (word_data)
	);

endmodule
`default_nettype wire

FILE: hdl/bsra_checker.sv
`default_nettype none
module bsra_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [1:0]  status,
	input wire logic [9:0]  bit_index,
	input wire logic [31:0] word_data
);

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == bsra_pkg::ST_OK || status == bsra_pkg::ST_NONE ||
		          status == bsra_pkg::ST_BAD))
		else $error("bad status code");

	a_fail_index: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bsra_pkg::ST_OK) |-> (bit_index == '0))
		else $error("failed transaction carries an index");

	a_fail_data: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != bsra_pkg::ST_OK) |-> (word_data == '0))
		else $error("failed transaction carries data");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (busy || done))
		else $error("accepted transaction dropped");

endmodule

bind bitmap_scan_range_allocator_top bsra_checker u_bsra_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.done      (done),
	.status    (status),
	.bit_index (bit_index),
	.word_data (word_data)
);
`default_nettype wire
